// ===== hw/rtl/aht_pkg.sv =====
// Shared types, sizes and codes for the allocation high-water tracker.
package aht_pkg;

  // Table geometry and field widths.
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned HANDLE_BITS = 48;
  localparam int unsigned SIZE_BITS   = 40;
  localparam int unsigned TOTAL_BITS  = 50;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [ADDR_W-1:0]     LAST_IDX  = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  // Event codes carried on the action field.
  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_PEAK   = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  // Result codes carried on the status field.
  typedef enum logic [2:0] {
    ST_RECORDED   = 3'd0,
    ST_IGNORED    = 3'd1,
    ST_DUPLICATE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_FREED      = 3'd4,
    ST_NOT_FOUND  = 3'd5,
    ST_PEAK_RESET = 3'd6,
    ST_REPORTED   = 3'd7
  } status_t;

  // One table slot as stored in the entry memory.
  typedef struct packed {
    logic                   valid;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/aht_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module aht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/allocation_high_water_tracker_unit.sv =====
// Allocation high-water tracker: after reset the block clears its entry memory and
// takes no event until that pass ends. An allocate or free event with a nonzero
// handle (and, for allocate, a nonzero size) walks the whole table through the single
// read port of the entry memory, one slot per cycle. Ignored events, peak resets and
// reports skip the scan. One event is worked on at a time; a new event is taken while
// the previous result still waits in the output register.
module allocation_high_water_tracker_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     action,
  input  logic [aht_pkg::HANDLE_BITS-1:0] handle,
  input  logic [aht_pkg::SIZE_BITS-1:0]  size_bytes,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [2:0]                     status,
  output logic [aht_pkg::TOTAL_BITS-1:0] current_total,
  output logic [aht_pkg::TOTAL_BITS-1:0] peak_total
);

  import aht_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  // Event held while it is worked on.
  action_t                act_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [SIZE_BITS-1:0]   size_q;
  status_t                status_q;

  // Scan bookkeeping.
  logic [ADDR_W-1:0]      clr_idx;
  logic [ADDR_W-1:0]      scan_idx;
  logic                   issuing;
  logic                   rd_pend;
  logic [ADDR_W-1:0]      rd_idx;
  logic                   match_found;
  logic [ADDR_W-1:0]      match_idx;
  logic [SIZE_BITS-1:0]   match_size;
  logic                   free_found;
  logic [ADDR_W-1:0]      free_idx;

  // Running totals.
  logic [TOTAL_BITS-1:0]  running_total;
  logic [TOTAL_BITS-1:0]  high_water;

  // Entry memory ports.
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  entry_t                 mem_wdata;
  entry_t                 mem_rdata;
  logic [ENTRY_W-1:0]     mem_rword;

  // Decisions taken at the end of a scan.
  logic                   commit_alloc;
  logic                   commit_free;
  logic [TOTAL_BITS:0]    add_sum;
  logic [TOTAL_BITS-1:0]  total_added;
  logic [TOTAL_BITS-1:0]  total_freed;
  logic [TOTAL_BITS-1:0]  match_size_w;
  logic                   hit;
  logic                   empty_slot;

  aht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_idx),
    .rdata (mem_rword)
  );

  assign mem_rdata = entry_t'(mem_rword);

  // Slot compare on the word returned by the memory.
  assign hit        = mem_rdata.valid && (mem_rdata.handle == handle_q);
  assign empty_slot = !mem_rdata.valid;

  // Outcome of the scan and the new totals.
  assign commit_alloc = (act_q == ACT_ALLOC) && !match_found && free_found;
  assign commit_free  = (act_q == ACT_FREE) && match_found;
  assign add_sum      = {1'b0, running_total} + (TOTAL_BITS + 1)'(size_q);
  assign total_added  = add_sum[TOTAL_BITS] ? TOTAL_MAX : add_sum[TOTAL_BITS-1:0];
  assign match_size_w = TOTAL_BITS'(match_size);
  assign total_freed  = (match_size_w > running_total) ? '0 : running_total - match_size_w;

  // Memory write: clearing pass, or the update of one slot after a scan.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WRITE) begin
      if (commit_alloc) begin
        mem_we           = 1'b1;
        mem_waddr        = free_idx;
        mem_wdata.valid  = 1'b1;
        mem_wdata.handle = handle_q;
        mem_wdata.size   = size_q;
      end else if (commit_free) begin
        mem_we    = 1'b1;
        mem_waddr = match_idx;
      end
    end
  end

  assign req_ready = (state == S_IDLE);

  // Control state, totals and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      issuing       <= 1'b0;
      rd_pend       <= 1'b0;
      match_found   <= 1'b0;
      free_found    <= 1'b0;
      running_total <= '0;
      high_water    <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            issuing     <= 1'b0;
            rd_pend     <= 1'b0;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            unique case (action_t'(action))
              ACT_ALLOC: begin
                if (handle == '0 || size_bytes == '0) begin
                  state <= S_DONE;
                end else begin
                  issuing <= 1'b1;
                  state   <= S_SCAN;
                end
              end
              ACT_FREE: begin
                if (handle == '0) begin
                  state <= S_DONE;
                end else begin
                  issuing <= 1'b1;
                  state   <= S_SCAN;
                end
              end
              ACT_PEAK: begin
                high_water <= running_total;
                state      <= S_DONE;
              end
              ACT_REPORT: begin
                state <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Issue one read a cycle and compare the word that comes back.
          rd_pend <= issuing;
          if (issuing && scan_idx == LAST_IDX) begin
            issuing <= 1'b0;
          end
          if (rd_pend) begin
            if (hit && !match_found) begin
              match_found <= 1'b1;
            end
            if (empty_slot && !free_found) begin
              free_found <= 1'b1;
            end
            if (rd_idx == LAST_IDX) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (commit_alloc) begin
            running_total <= total_added;
            if (total_added > high_water) begin
              high_water <= total_added;
            end
          end else if (commit_free) begin
            running_total <= total_freed;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Move the result out once the output register is free.
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Payload registers of the event, the scan and the result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        scan_idx <= '0;
        if (req_valid) begin
          act_q    <= action_t'(action);
          handle_q <= handle;
          size_q   <= size_bytes;
          unique case (action_t'(action))
            ACT_ALLOC:  status_q <= ST_IGNORED;
            ACT_FREE:   status_q <= ST_IGNORED;
            ACT_PEAK:   status_q <= ST_PEAK_RESET;
            ACT_REPORT: status_q <= ST_REPORTED;
            default:    status_q <= ST_REPORTED;
          endcase
        end
      end
      S_SCAN: begin
        if (issuing) begin
          rd_idx <= scan_idx;
          if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        if (rd_pend) begin
          if (hit && !match_found) begin
            match_idx  <= rd_idx;
            match_size <= mem_rdata.size;
          end
          if (empty_slot && !free_found) begin
            free_idx <= rd_idx;
          end
        end
      end
      S_WRITE: begin
        if (act_q == ACT_ALLOC) begin
          if (match_found) begin
            status_q <= ST_DUPLICATE;
          end else if (!free_found) begin
            status_q <= ST_FULL;
          end else begin
            status_q <= ST_RECORDED;
          end
        end else begin
          status_q <= match_found ? ST_FREED : ST_NOT_FOUND;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          status        <= status_q;
          current_total <= running_total;
          peak_total    <= high_water;
        end
      end
      default: begin
        scan_idx <= '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/aht_checker.sv =====
// Port-level checks for the allocation high-water tracker, bound to the top level.
module aht_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [2:0]                     status,
  input logic [aht_pkg::TOTAL_BITS-1:0] current_total,
  input logic [aht_pkg::TOTAL_BITS-1:0] peak_total
);

  import aht_pkg::*;

  // No result is offered right after reset.
  a_no_rsp_after_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result offered right after reset");

  // A stalled result keeps its totals.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(current_total) && $stable(peak_total))
    else $error("stalled result changed");

  // The peak never lies below the current total.
  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> peak_total >= current_total)
    else $error("peak below current total");

  // A peak reset reports the peak equal to the total.
  a_peak_reset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_PEAK_RESET |-> peak_total == current_total)
    else $error("peak reset left peak and total apart");

  // One event at a time: after a transfer in, the next is not taken at once.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("two events taken back to back");

endmodule

bind allocation_high_water_tracker_unit aht_checker u_aht_checker (.*);

// ===== dv/allocation_high_water_tracker_unit_tb.sv =====
// Self-checking testbench for the allocation high-water tracker unit.
`timescale 1ns / 100ps

module allocation_high_water_tracker_unit_tb;
  import aht_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 8_000_000;
  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned ROWS         = 23;

  localparam logic [HANDLE_BITS-1:0] HMAX = '1;
  localparam logic [SIZE_BITS-1:0]   SMAX = '1;
  localparam logic [TOTAL_BITS-1:0]  SMAX_T = TOTAL_BITS'(SMAX);

  // What one event should report.
  typedef struct {
    status_t               st;
    logic [TOTAL_BITS-1:0] cur;
    logic [TOTAL_BITS-1:0] peak;
  } tally_t;

  // One row of the directed script; typed expectations apply only where known is set.
  typedef struct {
    action_t                act;
    logic [HANDLE_BITS-1:0] h;
    logic [SIZE_BITS-1:0]   sz;
    bit                     known;
    status_t                st;
    logic [TOTAL_BITS-1:0]  cur;
    logic [TOTAL_BITS-1:0]  peak;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  logic [1:0]             action;
  logic [HANDLE_BITS-1:0] handle;
  logic [SIZE_BITS-1:0]   size_bytes;
  logic                   rsp_valid;
  logic                   rsp_ready;
  logic [2:0]             status;
  logic [TOTAL_BITS-1:0]  current_total;
  logic [TOTAL_BITS-1:0]  peak_total;

  // Shadow copy of the allocation table and its totals.
  logic [HANDLE_BITS-1:0] slot_handle [TABLE_DEPTH];
  logic [SIZE_BITS-1:0]   slot_size   [TABLE_DEPTH];
  bit                     slot_used   [TABLE_DEPTH];
  logic [TOTAL_BITS-1:0]  outstanding;
  logic [TOTAL_BITS-1:0]  peak_mark;
  logic [HANDLE_BITS-1:0] live_handles [$];

  tally_t      expected_reports [$];
  tally_t      head;
  row_t        script [ROWS];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned rsp_run;

  allocation_high_water_tracker_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .action        (action),
    .handle        (handle),
    .size_bytes    (size_bytes),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .current_total (current_total),
    .peak_total    (peak_total)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Applies one event to the shadow table and returns what the block should report.
  function automatic tally_t track_event(action_t act, logic [HANDLE_BITS-1:0] h,
                                         logic [SIZE_BITS-1:0] sz);
    tally_t                t;
    int                    hit;
    int                    gap_slot;
    logic [TOTAL_BITS:0]   sum;
    hit      = -1;
    gap_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot_used[i] && slot_handle[i] == h && hit < 0) hit = i;
      if (!slot_used[i] && gap_slot < 0) gap_slot = i;
    end
    case (act)
      ACT_ALLOC: begin
        if (h == '0 || sz == '0) t.st = ST_IGNORED;
        else if (hit >= 0) t.st = ST_DUPLICATE;
        else if (gap_slot < 0) t.st = ST_FULL;
        else begin
          slot_used[gap_slot]   = 1'b1;
          slot_handle[gap_slot] = h;
          slot_size[gap_slot]   = sz;
          live_handles.push_back(h);
          sum = {1'b0, outstanding} + (TOTAL_BITS + 1)'(sz);
          outstanding = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
          if (outstanding > peak_mark) peak_mark = outstanding;
          t.st = ST_RECORDED;
        end
      end
      ACT_FREE: begin
        if (h == '0) t.st = ST_IGNORED;
        else if (hit < 0) t.st = ST_NOT_FOUND;
        else begin
          if (TOTAL_BITS'(slot_size[hit]) > outstanding) outstanding = '0;
          else outstanding = outstanding - TOTAL_BITS'(slot_size[hit]);
          slot_used[hit] = 1'b0;
          for (int k = 0; k < live_handles.size(); k++) begin
            if (live_handles[k] == h) begin
              live_handles.delete(k);
              break;
            end
          end
          t.st = ST_FREED;
        end
      end
      ACT_PEAK: begin
        peak_mark = outstanding;
        t.st = ST_PEAK_RESET;
      end
      default: t.st = ST_REPORTED;
    endcase
    t.cur  = outstanding;
    t.peak = peak_mark;
    return t;
  endfunction

  // Drives one event, in bursts with random gaps, and records its expectation on transfer.
  task automatic push_event(action_t act, logic [HANDLE_BITS-1:0] h,
                            logic [SIZE_BITS-1:0] sz, bit known, tally_t typed);
    tally_t      t;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_valid  <= 1'b1;
    action     <= act;
    handle     <= h;
    size_bytes <= sz;
    do @(posedge clk); while (!req_ready);
    t = track_event(act, h, sz);
    if (known) t = typed;
    expected_reports.push_back(t);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    req_valid  <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  function automatic logic [HANDLE_BITS-1:0] any_handle();
    return HANDLE_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [SIZE_BITS-1:0] any_size();
    case ($urandom_range(0, 3))
      0:       return SMAX;
      1:       return SIZE_BITS'($urandom_range(1, 4096));
      default: return SIZE_BITS'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [HANDLE_BITS-1:0] some_live_handle();
    if (live_handles.size() == 0) return any_handle();
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  // One random event, weighted toward allocations and frees of live handles.
  task automatic random_event();
    tally_t                 none;
    int unsigned            pick;
    int unsigned            sub;
    logic [HANDLE_BITS-1:0] h;
    logic [SIZE_BITS-1:0]   sz;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 19);
    h    = any_handle();
    sz   = any_size();
    none = '{ST_RECORDED, '0, '0};
    if (pick < 45) begin
      if (sub == 0) h = '0;
      else if (sub == 1) sz = '0;
      else if (sub < 4) h = some_live_handle();
      push_event(ACT_ALLOC, h, sz, 1'b0, none);
    end else if (pick < 80) begin
      if (sub == 0) h = '0;
      else if (sub > 2) h = some_live_handle();
      push_event(ACT_FREE, h, sz, 1'b0, none);
    end else if (pick < 90) begin
      push_event(ACT_PEAK, h, sz, 1'b0, none);
    end else begin
      push_event(ACT_REPORT, h, sz, 1'b0, none);
    end
  endtask

  // Receiver alternates ready runs and stalls, with an occasional long run without stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_run   <= 0;
    end else if (rsp_run > 0) begin
      rsp_run <= rsp_run - 1;
    end else begin
      rsp_ready <= !rsp_ready;
      rsp_run   <= rsp_ready ? $urandom_range(0, 12)
                             : (($urandom_range(0, 7) == 0) ? 400 : $urandom_range(1, 30));
    end
  end

  // Compares each result transfer with the oldest expectation; also guards the run length.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result: status %0d, current_total %0d, peak_total %0d",
               status, current_total, peak_total);
        mismatch_count++;
      end else begin
        head = expected_reports.pop_front();
        if (status !== head.st) begin
          $error("status: expected %0d, actual %0d", head.st, status);
          mismatch_count++;
        end
        if (current_total !== head.cur) begin
          $error("current_total: expected %0d, actual %0d", head.cur, current_total);
          mismatch_count++;
        end
        if (peak_total !== head.peak) begin
          $error("peak_total: expected %0d, actual %0d", head.peak, peak_total);
          mismatch_count++;
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("allocation_high_water_tracker_unit test failed");
      $finish;
    end
  end

  // Main sequence: directed script, random events, a few closing probes, then drain.
  initial begin
    tally_t none;
    none           = '{ST_RECORDED, '0, '0};
    burst_left     = 0;
    outstanding    = '0;
    peak_mark      = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;

    rst        <= 1'b1;
    req_valid  <= 1'b0;
    action     <= ACT_REPORT;
    handle     <= '0;
    size_bytes <= '0;

    // Directed script: null inputs, extremes, duplicates past a freed slot, double free.
    script = '{
      '{ACT_REPORT, '0,   '0,   1'b1, ST_REPORTED,   '0,     '0},
      '{ACT_PEAK,   HMAX, SMAX, 1'b1, ST_PEAK_RESET, '0,     '0},
      '{ACT_ALLOC,  '0,   SMAX, 1'b1, ST_IGNORED,    '0,     '0},
      '{ACT_ALLOC,  HMAX, '0,   1'b1, ST_IGNORED,    '0,     '0},
      '{ACT_FREE,   '0,   SMAX, 1'b1, ST_IGNORED,    '0,     '0},
      '{ACT_FREE,   HMAX, '0,   1'b1, ST_NOT_FOUND,  '0,     '0},
      '{ACT_ALLOC,  HMAX, SMAX, 1'b1, ST_RECORDED,   SMAX_T, SMAX_T},
      '{ACT_ALLOC,  48'h1, 40'h1, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_ALLOC,  HMAX, 40'h5, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_FREE,   HMAX, '0,   1'b0, ST_RECORDED, '0, '0},
      '{ACT_ALLOC,  48'h1, 40'h77, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_PEAK,   '0,   '0,   1'b0, ST_RECORDED, '0, '0},
      '{ACT_ALLOC,  48'h8000_0000_0000, 40'h80_0000_0000, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_ALLOC,  48'h5555_5555_5555, 40'hAA_AAAA_AAAA, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_ALLOC,  48'hAAAA_AAAA_AAAA, 40'h55_5555_5555, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_REPORT, HMAX, SMAX, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_FREE,   48'h5555_5555_5555, SMAX, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_FREE,   48'h5555_5555_5555, '0, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_PEAK,   '0,   '0,   1'b0, ST_RECORDED, '0, '0},
      '{ACT_FREE,   48'h1, '0,  1'b0, ST_RECORDED, '0, '0},
      '{ACT_FREE,   48'h8000_0000_0000, '0, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_FREE,   48'hAAAA_AAAA_AAAA, '0, 1'b0, ST_RECORDED, '0, '0},
      '{ACT_REPORT, '0,   '0,   1'b0, ST_RECORDED, '0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      push_event(script[r].act, script[r].h, script[r].sz, script[r].known,
                 '{script[r].st, script[r].cur, script[r].peak});
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) random_event();
    drain_results();

    // Closing probes: a fresh allocation, a duplicate, a free and the extreme handles.
    push_event(ACT_ALLOC, any_handle() | HANDLE_BITS'(1), any_size() | SIZE_BITS'(1),
               1'b0, none);
    push_event(ACT_ALLOC, some_live_handle(), SMAX, 1'b0, none);
    push_event(ACT_FREE, some_live_handle(), '0, 1'b0, none);
    push_event(ACT_ALLOC, HMAX, SMAX, 1'b0, none);
    push_event(ACT_ALLOC, HMAX - 1, SMAX, 1'b0, none);
    push_event(ACT_REPORT, '0, '0, 1'b0, none);
    drain_results();

    // Quiet period to catch any stray result after the last one.
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("allocation_high_water_tracker_unit test passed");
    end else begin
      $display("allocation_high_water_tracker_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/aht_pkg.sv
hw/rtl/aht_ram.sv
hw/rtl/allocation_high_water_tracker_unit.sv
hw/rtl/aht_checker.sv
dv/allocation_high_water_tracker_unit_tb.sv
